### hw/rtl/ppc_pkg.sv
// Shared constants for the PWM pulse position classifier: command codes,
// stick state codes, register indexes and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

   // Default structural sizes.
   localparam int DEF_NUM_CHANNELS  = 2;
   localparam int DEF_TIME_BITS     = 16;
   localparam int DEF_RUN_COUNT_MAX = 255;

   // Only channels 0 and 1 can be addressed by an edge request.
   localparam int EDGE_CHANNELS = 2;

   // Field widths.
   localparam int CMD_BITS     = 2;
   localparam int STATE_BITS   = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int WIN_BITS     = 32;
   localparam int CTRL_BITS    = 26;
   localparam int TIMEOUT_BITS = 9;
   localparam int BAD_BITS     = 8;
   localparam int NUM_BANDS    = 4;

   // Saturation limits.
   localparam logic [BAD_BITS-1:0]     BAD_MAX   = 8'hff;
   localparam logic [TIMEOUT_BITS-1:0] TIMER_MAX = 9'h1ff;

   // Request commands.
   localparam logic [CMD_BITS-1:0] CMD_RISE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FALL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd2;

   // Stick states; the ordering matters for the demotion rules.
   localparam logic [STATE_BITS-1:0] ST_NO_STICK = 3'd0;
   localparam logic [STATE_BITS-1:0] ST_LOST     = 3'd1;
   localparam logic [STATE_BITS-1:0] ST_POS1     = 3'd2;
   localparam logic [STATE_BITS-1:0] ST_POS2     = 3'd3;
   localparam logic [STATE_BITS-1:0] ST_POS3     = 3'd4;

   // Band indexes within a channel's run counters.
   localparam int BAND_POS1 = 0;
   localparam int BAND_POS2 = 1;
   localparam int BAND_POS3 = 2;
   localparam int BAND_LOST = 3;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] REG_POS1_WINDOW   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_POS2_WINDOW   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_POS3_WINDOW   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LOST_WINDOW   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PERIOD_WINDOW = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_CONTROL       = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_LOST_TIMEOUT  = 3'd6;

   // Register reset values.
   localparam logic [WIN_BITS-1:0]     RST_POS1_WINDOW   = 32'd7209050;
   localparam logic [WIN_BITS-1:0]     RST_POS2_WINDOW   = 32'd10485900;
   localparam logic [WIN_BITS-1:0]     RST_POS3_WINDOW   = 32'd13762750;
   localparam logic [WIN_BITS-1:0]     RST_LOST_WINDOW   = 32'd0;
   localparam logic [WIN_BITS-1:0]     RST_PERIOD_WINDOW = 32'd144181000;
   localparam logic [CTRL_BITS-1:0]    RST_CONTROL       = 26'd16974595;
   localparam logic [TIMEOUT_BITS-1:0] RST_LOST_TIMEOUT  = 9'd100;

   // Control word fields.
   localparam int CTRL_DETECT_LSB = 0;
   localparam int CTRL_PER_TOL_LSB = 8;
   localparam int CTRL_WID_TOL_LSB = 16;
   localparam int CTRL_SCAN_LSB = 24;

endpackage

### hw/rtl/pwm_pulse_position_classifier.sv
// Top level of the PWM pulse position classifier: edge timing, band
// classification, tolerance filters and lost timers for each channel.
// Depends on ppc_pkg.
`timescale 1ns / 1ps

//  Channel   Direction   Handshake              Payload
//  req_      in          req_valid / req_stall  req_cmd, req_channel, req_timestamp
//  rsp_      out         rsp_valid / rsp_stall  rsp_chan_out, rsp_stick_state
//  csr_      in          csr_valid / csr_ready  csr_index, csr_wdata
//
// A request is registered in the request register, then updated into the
// channel state and the result register by the single state update stage;
// one request per cycle is taken while no response is held.
// Synchronous active-high reset restores all registers but the data payloads.
// A waiting response holds the update stage; one more request is still taken.
// csr_ready is always high; writes to indexes past the list are dropped.

module pwm_pulse_position_classifier #(
   parameter int NUM_CHANNELS  = ppc_pkg::DEF_NUM_CHANNELS,
   parameter int TIME_BITS     = ppc_pkg::DEF_TIME_BITS,
   parameter int RUN_COUNT_MAX = ppc_pkg::DEF_RUN_COUNT_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ppc_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic                                req_channel,
   input  logic [TIME_BITS-1:0]                req_timestamp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_chan_out,
   output logic [ppc_pkg::STATE_BITS-1:0]      rsp_stick_state,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ppc_pkg::WIN_BITS-1:0]        csr_wdata
);

   localparam int RUN_BITS = $clog2(RUN_COUNT_MAX + 1);
   localparam int CMP_BITS = (RUN_BITS > ppc_pkg::BAD_BITS) ? RUN_BITS : ppc_pkg::BAD_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX = RUN_BITS'(RUN_COUNT_MAX);

   // Interval between two stamps; the wrap case is the all-ones mask minus
   // the backward difference, which equals the forward difference minus one.
   function automatic logic [TIME_BITS-1:0] span_f(input logic [TIME_BITS-1:0] start_t,
                                                   input logic [TIME_BITS-1:0] end_t);
      logic [TIME_BITS-1:0] diff;
      diff = end_t - start_t;
      if (end_t > start_t) begin
         return diff;
      end
      return diff - TIME_BITS'(1);
   endfunction

   // Both window bounds are exclusive.
   function automatic logic in_window_f(input logic [ppc_pkg::WIN_BITS-1:0] win,
                                        input logic [TIME_BITS-1:0] v);
      logic [31:0] vx;
      vx = 32'(v);
      return (vx > {16'b0, win[15:0]}) && (vx < {16'b0, win[31:16]});
   endfunction

   function automatic logic [ppc_pkg::BAD_BITS-1:0] bad_inc_f(
         input logic [ppc_pkg::BAD_BITS-1:0] cnt);
      if (cnt < ppc_pkg::BAD_MAX) begin
         return cnt + ppc_pkg::BAD_BITS'(1);
      end
      return cnt;
   endfunction

   // Configuration registers.
   logic [ppc_pkg::WIN_BITS-1:0]     pos1_win_ff, pos2_win_ff, pos3_win_ff;
   logic [ppc_pkg::WIN_BITS-1:0]     lost_win_ff, period_win_ff;
   logic [ppc_pkg::CTRL_BITS-1:0]    ctrl_ff;
   logic [ppc_pkg::TIMEOUT_BITS-1:0] timeout_ff;

   // Request register stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic [ppc_pkg::CMD_BITS-1:0]  s1_cmd_ff;
   logic                          s1_chan_ff;
   logic [TIME_BITS-1:0]          s1_ts_ff;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_chan_ff;
   logic [ppc_pkg::STATE_BITS-1:0]  rsp_state_ff;

   logic req_fire;
   logic s1_fire;
   logic out_block;

   logic [NUM_CHANNELS-1:0]         emit;
   logic [ppc_pkg::STATE_BITS-1:0]  emit_state [NUM_CHANNELS];
   logic                            any_emit;
   logic [ppc_pkg::STATE_BITS-1:0]  sel_state;

   logic [ppc_pkg::BAD_BITS-1:0] detect, per_tol, wid_tol;

   assign detect  = ctrl_ff[ppc_pkg::CTRL_DETECT_LSB +: ppc_pkg::BAD_BITS];
   assign per_tol = ctrl_ff[ppc_pkg::CTRL_PER_TOL_LSB +: ppc_pkg::BAD_BITS];
   assign wid_tol = ctrl_ff[ppc_pkg::CTRL_WID_TOL_LSB +: ppc_pkg::BAD_BITS];

   // Handshake control: the update stage waits while a response is held.
   assign out_block = rsp_valid_ff && rsp_stall;
   assign s1_fire   = s1_valid_ff && !out_block;
   assign req_stall = s1_valid_ff && out_block;
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chan_out    = rsp_chan_ff;
   assign rsp_stick_state = rsp_state_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos1_win_ff   <= ppc_pkg::RST_POS1_WINDOW;
         pos2_win_ff   <= ppc_pkg::RST_POS2_WINDOW;
         pos3_win_ff   <= ppc_pkg::RST_POS3_WINDOW;
         lost_win_ff   <= ppc_pkg::RST_LOST_WINDOW;
         period_win_ff <= ppc_pkg::RST_PERIOD_WINDOW;
         ctrl_ff       <= ppc_pkg::RST_CONTROL;
         timeout_ff    <= ppc_pkg::RST_LOST_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppc_pkg::REG_POS1_WINDOW:   pos1_win_ff   <= csr_wdata;
            ppc_pkg::REG_POS2_WINDOW:   pos2_win_ff   <= csr_wdata;
            ppc_pkg::REG_POS3_WINDOW:   pos3_win_ff   <= csr_wdata;
            ppc_pkg::REG_LOST_WINDOW:   lost_win_ff   <= csr_wdata;
            ppc_pkg::REG_PERIOD_WINDOW: period_win_ff <= csr_wdata;
            ppc_pkg::REG_CONTROL:       ctrl_ff       <= csr_wdata[ppc_pkg::CTRL_BITS-1:0];
            ppc_pkg::REG_LOST_TIMEOUT:  timeout_ff    <= csr_wdata[ppc_pkg::TIMEOUT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_cmd_ff  <= req_cmd;
         s1_chan_ff <= req_channel;
         s1_ts_ff   <= req_timestamp;
      end
   end

   // Per-channel state and update logic.
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      localparam logic IS_EDGE_CHAN = (c < ppc_pkg::EDGE_CHANNELS);
      localparam logic CHAN_ID = 1'(c % ppc_pkg::EDGE_CHANNELS);

      logic [TIME_BITS-1:0]             last_rise_ff, period_ff;
      logic [RUN_BITS-1:0]              runs_ff [ppc_pkg::NUM_BANDS];
      logic [RUN_BITS-1:0]              runs_in [ppc_pkg::NUM_BANDS];
      logic [ppc_pkg::BAD_BITS-1:0]     per_bad_ff, per_bad_in;
      logic [ppc_pkg::BAD_BITS-1:0]     wid_bad_ff, wid_bad_in;
      logic [ppc_pkg::STATE_BITS-1:0]   state_ff, state_in, demoted;
      logic [ppc_pkg::TIMEOUT_BITS-1:0] timer_ff, timer_inc;
      logic                             armed_ff;

      logic                       hit, rise, fall, tick, classify, scan_en;
      logic [TIME_BITS-1:0]       span_v;
      logic [ppc_pkg::NUM_BANDS-1:0] in_band, band_sel;
      logic                       per_in, per_ok, wid_ok, timer_fire;

      assign hit     = IS_EDGE_CHAN && (s1_chan_ff == CHAN_ID);
      assign rise    = s1_fire && (s1_cmd_ff == ppc_pkg::CMD_RISE) && hit;
      assign fall    = s1_fire && (s1_cmd_ff == ppc_pkg::CMD_FALL) && hit;
      assign tick    = s1_fire && (s1_cmd_ff == ppc_pkg::CMD_TICK);
      assign scan_en = IS_EDGE_CHAN &&
                       ctrl_ff[ppc_pkg::CTRL_SCAN_LSB + (c % ppc_pkg::EDGE_CHANNELS)];
      assign classify = fall && scan_en;
      assign span_v  = span_f(last_rise_ff, s1_ts_ff);

      // Band match, first band in the order position 1, 2, 3, lost wins.
      assign in_band[ppc_pkg::BAND_POS1] = in_window_f(pos1_win_ff, span_v);
      assign in_band[ppc_pkg::BAND_POS2] = in_window_f(pos2_win_ff, span_v);
      assign in_band[ppc_pkg::BAND_POS3] = in_window_f(pos3_win_ff, span_v);
      assign in_band[ppc_pkg::BAND_LOST] = in_window_f(lost_win_ff, span_v);
      assign band_sel = in_band & (~in_band + ppc_pkg::NUM_BANDS'(1));

      // Run counters: the matched band counts up, all others clear.
      always_comb begin
         for (int b = 0; b < ppc_pkg::NUM_BANDS; b++) begin
            if (!band_sel[b]) begin
               runs_in[b] = '0;
            end else if (runs_ff[b] < RUN_MAX) begin
               runs_in[b] = runs_ff[b] + RUN_BITS'(1);
            end else begin
               runs_in[b] = runs_ff[b];
            end
         end
      end

      // Tolerance filters for period and width.
      assign per_in     = in_window_f(period_win_ff, period_ff);
      assign per_bad_in = per_in ? '0 : bad_inc_f(per_bad_ff);
      assign per_ok     = per_in || (per_bad_in < per_tol);
      assign wid_bad_in = (|in_band) ? '0 : bad_inc_f(wid_bad_ff);
      assign wid_ok     = (|in_band) || (wid_bad_in < wid_tol);

      // Stick state after a classified falling edge; a lost run has the final say.
      always_comb begin
         state_in = state_ff;
         if (!per_ok || !wid_ok) begin
            state_in = (state_ff == ppc_pkg::ST_NO_STICK) ? ppc_pkg::ST_NO_STICK
                                                          : ppc_pkg::ST_LOST;
         end
         priority if (CMP_BITS'(runs_in[ppc_pkg::BAND_LOST]) > CMP_BITS'(detect)) begin
            state_in = ppc_pkg::ST_LOST;
         end else if (CMP_BITS'(runs_in[ppc_pkg::BAND_POS3]) > CMP_BITS'(detect)) begin
            state_in = ppc_pkg::ST_POS3;
         end else if (CMP_BITS'(runs_in[ppc_pkg::BAND_POS2]) > CMP_BITS'(detect)) begin
            state_in = ppc_pkg::ST_POS2;
         end else if (CMP_BITS'(runs_in[ppc_pkg::BAND_POS1]) > CMP_BITS'(detect)) begin
            state_in = ppc_pkg::ST_POS1;
         end else begin
         end
      end

      assign emit[c]       = classify && (state_in != state_ff);
      assign emit_state[c] = state_in;

      // Lost timer advance and silent demotion.
      assign timer_inc  = (timer_ff < ppc_pkg::TIMER_MAX) ?
                          timer_ff + ppc_pkg::TIMEOUT_BITS'(1) : timer_ff;
      assign timer_fire = timer_inc >= timeout_ff;
      assign demoted    = (state_ff < ppc_pkg::ST_POS1) ? ppc_pkg::ST_NO_STICK
                                                        : ppc_pkg::ST_LOST;

      always_ff @(posedge clock) begin
         if (reset) begin
            last_rise_ff <= '0;
            period_ff    <= '0;
            per_bad_ff   <= '0;
            wid_bad_ff   <= '0;
            state_ff     <= ppc_pkg::ST_NO_STICK;
            timer_ff     <= '0;
            armed_ff     <= (c == 0);
            for (int b = 0; b < ppc_pkg::NUM_BANDS; b++) begin
               runs_ff[b] <= '0;
            end
         end else begin
            if (rise) begin
               period_ff    <= span_v;
               last_rise_ff <= s1_ts_ff;
            end
            if (classify) begin
               per_bad_ff <= per_bad_in;
               wid_bad_ff <= wid_bad_in;
               state_ff   <= state_in;
               timer_ff   <= '0;
               armed_ff   <= 1'b1;
               for (int b = 0; b < ppc_pkg::NUM_BANDS; b++) begin
                  runs_ff[b] <= runs_in[b];
               end
            end else if (tick && armed_ff) begin
               if (timer_fire) begin
                  timer_ff <= '0;
                  armed_ff <= 1'b0;
                  state_ff <= demoted;
               end else begin
                  timer_ff <= timer_inc;
               end
            end
         end
      end
   end

   // Pick the state of the channel that reports; at most one does.
   always_comb begin
      sel_state = ppc_pkg::ST_NO_STICK;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (emit[c]) begin
            sel_state = emit_state[c];
         end
      end
   end
   assign any_emit = |emit;

   // Result register.
   always_comb begin
      if (s1_fire) begin
         rsp_valid_in = any_emit;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire && any_emit) begin
         rsp_chan_ff  <= s1_chan_ff;
         rsp_state_ff <= sel_state;
      end
   end

endmodule

### hw/rtl/ppc_checker.sv
// Port-level checks for the PWM pulse position classifier, bound to the
// top level. Depends on ppc_pkg and pwm_pulse_position_classifier.
`timescale 1ns / 1ps

module ppc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_chan_out,
   input logic [ppc_pkg::STATE_BITS-1:0]  rsp_stick_state
);

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chan_out) && $stable(rsp_stick_state))
      else $error("held response changed");

   // Only legal stick states are reported.
   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stick_state <= ppc_pkg::ST_POS3)
      else $error("illegal stick state reported");

   // Request backpressure only ever comes from a held response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pwm_pulse_position_classifier ppc_checker u_ppc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_chan_out    (rsp_chan_out),
   .rsp_stick_state (rsp_stick_state)
);

### tb/sv/tb.sv
// Self-checking testbench for the PWM pulse position classifier: directed and
// random edge and tick requests, checked against a cycle-free predictor.
// Depends on ppc_pkg and pwm_pulse_position_classifier.
`timescale 1ns / 1ps

module tb;

   localparam int TB_TIME_BITS = ppc_pkg::DEF_TIME_BITS;
   localparam int RUN_BITS     = $clog2(ppc_pkg::DEF_RUN_COUNT_MAX + 1);
   localparam int NUM_WINDOWS  = 5;
   localparam int PHASE_ITEMS  = 270;
   localparam int NUM_PHASES   = 7;
   localparam int HOLD_CYCLES  = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT  = 3000;

   // Codes the block must ignore.
   localparam logic [ppc_pkg::CMD_BITS-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [ppc_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef logic [TB_TIME_BITS-1:0] stamp_type;

   typedef struct {
      logic [ppc_pkg::CMD_BITS-1:0] cmd;
      logic                         chan;
      stamp_type                    stamp;
   } pwm_req_type;

   typedef struct {
      bit                             hit;
      logic                           chan;
      logic [ppc_pkg::STATE_BITS-1:0] state;
   } stick_change_type;

   // Block ports, all inputs known from time zero.
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [ppc_pkg::CMD_BITS-1:0]     req_cmd = ppc_pkg::CMD_RISE;
   logic                             req_channel = 1'b0;
   stamp_type                        req_timestamp = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_chan_out;
   logic [ppc_pkg::STATE_BITS-1:0]   rsp_stick_state;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ppc_pkg::CSR_IDX_BITS-1:0] csr_index = ppc_pkg::REG_POS1_WINDOW;
   logic [ppc_pkg::WIN_BITS-1:0]     csr_wdata = '0;

   pwm_pulse_position_classifier u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_channel     (req_channel),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chan_out    (rsp_chan_out),
      .rsp_stick_state (rsp_stick_state),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers and the per-channel state.
   logic [ppc_pkg::WIN_BITS-1:0]     cfg_win [NUM_WINDOWS];
   logic [ppc_pkg::CTRL_BITS-1:0]    cfg_ctrl;
   logic [ppc_pkg::TIMEOUT_BITS-1:0] cfg_timeout;
   stamp_type                        rise_at [ppc_pkg::EDGE_CHANNELS];
   stamp_type                        period_of [ppc_pkg::EDGE_CHANNELS];
   stamp_type                        width_of [ppc_pkg::EDGE_CHANNELS];
   logic [RUN_BITS-1:0]      band_runs [ppc_pkg::EDGE_CHANNELS][ppc_pkg::NUM_BANDS];
   logic [ppc_pkg::BAD_BITS-1:0]     period_bad [ppc_pkg::EDGE_CHANNELS];
   logic [ppc_pkg::BAD_BITS-1:0]     width_bad [ppc_pkg::EDGE_CHANNELS];
   logic [ppc_pkg::STATE_BITS-1:0]   stick [ppc_pkg::EDGE_CHANNELS];
   logic [ppc_pkg::TIMEOUT_BITS-1:0] lost_timer [ppc_pkg::EDGE_CHANNELS];
   bit                               lost_armed [ppc_pkg::EDGE_CHANNELS];

   // Requests waiting for the driver and state changes waiting for the block.
   pwm_req_type      pending_reqs[$];
   stick_change_type state_changes_due[$];

   // Run control and bookkeeping.
   stamp_type gen_rise [ppc_pkg::EDGE_CHANNELS];
   bit     req_took = 1'b0;
   bit     hold_request = 1'b0;
   int     hold_left = 0;
   int     sender_idle_pct = 0;
   int     rsp_stall_pct = 0;
   int     queued = 0;
   int     errors = 0;
   int     quiet_cycles = 0;
   int     results_seen = 0;
   int     reg_writes = 0;
   int     settings = 1;
   int     cmd_seen [4];
   int     state_seen [5];

   // Counter distance between two stamps; a backward step folds as 0xffff minus the gap.
   function automatic stamp_type elapsed(input stamp_type from_t, input stamp_type to_t);
      if (to_t > from_t) return to_t - from_t;
      return {TB_TIME_BITS{1'b1}} - (from_t - to_t);
   endfunction

   // Both bounds of a window are exclusive.
   function automatic bit in_band(input logic [ppc_pkg::WIN_BITS-1:0] win, input stamp_type v);
      return v > win[15:0] && v < win[31:16];
   endfunction

   // Applies one request to the predictor state and returns the state change it reports.
   function automatic stick_change_type predict_stick_change(input pwm_req_type r);
      stick_change_type               chg;
      logic [ppc_pkg::STATE_BITS-1:0] st;
      logic [7:0]                     detect;
      int                             ch;
      int                             band;
      bit                             per_ok;
      bit                             wid_ok;
      chg.hit = 1'b0;
      chg.chan = r.chan;
      chg.state = ppc_pkg::ST_NO_STICK;
      ch = r.chan;
      case (r.cmd)
         ppc_pkg::CMD_TICK: begin
            // Every armed lost timer advances; on expiry the state drops quietly.
            for (int c = 0; c < ppc_pkg::EDGE_CHANNELS; c++) begin
               if (lost_armed[c]) begin
                  if (lost_timer[c] < ppc_pkg::TIMER_MAX) lost_timer[c]++;
                  if (lost_timer[c] >= cfg_timeout) begin
                     lost_timer[c] = '0;
                     lost_armed[c] = 1'b0;
                     stick[c] = (stick[c] < ppc_pkg::ST_POS1) ? ppc_pkg::ST_NO_STICK
                                                              : ppc_pkg::ST_LOST;
                  end
               end
            end
         end
         ppc_pkg::CMD_RISE: begin
            period_of[ch] = elapsed(rise_at[ch], r.stamp);
            rise_at[ch] = r.stamp;
         end
         ppc_pkg::CMD_FALL: begin
            width_of[ch] = elapsed(rise_at[ch], r.stamp);
            if (cfg_ctrl[ppc_pkg::CTRL_SCAN_LSB + ch]) begin
               lost_timer[ch] = '0;
               lost_armed[ch] = 1'b1;
               detect = cfg_ctrl[ppc_pkg::CTRL_DETECT_LSB +: 8];

               // Period filter: a bad period is forgiven while its count stays under tolerance.
               per_ok = in_band(cfg_win[ppc_pkg::REG_PERIOD_WINDOW], period_of[ch]);
               if (per_ok) period_bad[ch] = '0;
               else if (period_bad[ch] != ppc_pkg::BAD_MAX) period_bad[ch]++;
               per_ok = per_ok || period_bad[ch] < cfg_ctrl[ppc_pkg::CTRL_PER_TOL_LSB +: 8];

               // First matching band wins; band indexes match the window register indexes.
               band = -1;
               for (int b = ppc_pkg::BAND_LOST; b >= ppc_pkg::BAND_POS1; b--)
                  if (in_band(cfg_win[b], width_of[ch])) band = b;
               for (int b = 0; b < ppc_pkg::NUM_BANDS; b++) begin
                  if (b == band) begin
                     if (band_runs[ch][b] < ppc_pkg::DEF_RUN_COUNT_MAX) band_runs[ch][b]++;
                  end else begin
                     band_runs[ch][b] = '0;
                  end
               end

               wid_ok = band >= 0;
               if (wid_ok) width_bad[ch] = '0;
               else if (width_bad[ch] != ppc_pkg::BAD_MAX) width_bad[ch]++;
               wid_ok = wid_ok || width_bad[ch] < cfg_ctrl[ppc_pkg::CTRL_WID_TOL_LSB +: 8];

               st = stick[ch];
               if (!per_ok || !wid_ok)
                  st = (st < ppc_pkg::ST_LOST) ? ppc_pkg::ST_NO_STICK : ppc_pkg::ST_LOST;
               if (band_runs[ch][ppc_pkg::BAND_POS1] > detect) st = ppc_pkg::ST_POS1;
               if (band_runs[ch][ppc_pkg::BAND_POS2] > detect) st = ppc_pkg::ST_POS2;
               if (band_runs[ch][ppc_pkg::BAND_POS3] > detect) st = ppc_pkg::ST_POS3;
               if (band_runs[ch][ppc_pkg::BAND_LOST] > detect) st = ppc_pkg::ST_LOST;
               if (st != stick[ch]) begin
                  chg.hit = 1'b1;
                  chg.state = st;
                  stick[ch] = st;
               end
            end
         end
         default: ;
      endcase
      return chg;
   endfunction

   // A value strictly inside a window, or any value when the window is empty.
   function automatic stamp_type pick_in(input logic [ppc_pkg::WIN_BITS-1:0] win);
      int lo;
      int hi;
      lo = win[15:0];
      hi = win[31:16];
      if (hi > lo + 1) return stamp_type'(lo + 1 + $urandom_range(0, hi - lo - 2));
      return stamp_type'($urandom_range(0, 65535));
   endfunction

   function automatic logic [ppc_pkg::WIN_BITS-1:0] rand_window(input int lo_min,
                                                                input int lo_max,
                                                                input int span_max);
      int lo;
      lo = $urandom_range(lo_min, lo_max);
      return {16'(lo + $urandom_range(0, span_max)), 16'(lo)};
   endfunction

   task automatic push_req(input logic [ppc_pkg::CMD_BITS-1:0] cmd, input logic chan,
                           input stamp_type stamp);
      pwm_req_type r;
      r.cmd = cmd;
      r.chan = chan;
      r.stamp = stamp;
      pending_reqs.push_back(r);
      if (cmd != CMD_UNUSED) queued++;
   endtask

   // Register write; the predictor takes the value at the accepting edge.
   task automatic write_reg(input logic [ppc_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [ppc_pkg::WIN_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ppc_pkg::REG_POS1_WINDOW, ppc_pkg::REG_POS2_WINDOW, ppc_pkg::REG_POS3_WINDOW,
         ppc_pkg::REG_LOST_WINDOW, ppc_pkg::REG_PERIOD_WINDOW: cfg_win[idx] = data;
         ppc_pkg::REG_CONTROL:      cfg_ctrl = data[ppc_pkg::CTRL_BITS-1:0];
         ppc_pkg::REG_LOST_TIMEOUT: cfg_timeout = data[ppc_pkg::TIMEOUT_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input logic [ppc_pkg::WIN_BITS-1:0] pos1,
                               input logic [ppc_pkg::WIN_BITS-1:0] pos2,
                               input logic [ppc_pkg::WIN_BITS-1:0] pos3,
                               input logic [ppc_pkg::WIN_BITS-1:0] lost,
                               input logic [ppc_pkg::WIN_BITS-1:0] per,
                               input logic [ppc_pkg::WIN_BITS-1:0] ctrl,
                               input logic [ppc_pkg::WIN_BITS-1:0] tmo);
      write_reg(ppc_pkg::REG_POS1_WINDOW, pos1);
      write_reg(ppc_pkg::REG_POS2_WINDOW, pos2);
      write_reg(ppc_pkg::REG_POS3_WINDOW, pos3);
      write_reg(ppc_pkg::REG_LOST_WINDOW, lost);
      write_reg(ppc_pkg::REG_PERIOD_WINDOW, per);
      write_reg(ppc_pkg::REG_CONTROL, ctrl);
      write_reg(ppc_pkg::REG_LOST_TIMEOUT, tmo);
      settings++;
   endtask

   // Waits until every request is taken and every state change has come back.
   task automatic settle();
      while (pending_reqs.size() != 0 || req_valid || state_changes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: a stalled request holds its payload.
   always @(negedge clock) begin
      pwm_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= r.cmd;
            req_channel <= r.chan;
            req_timestamp <= r.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: random, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Monitor: check responses, predict accepted requests, and watch for a hang.
   always @(posedge clock) begin
      stick_change_type want;
      stick_change_type chg;
      pwm_req_type      seen;
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (state_changes_due.size() == 0) begin
               $error("unexpected response: chan_out %0d stick_state %0d",
                      rsp_chan_out, rsp_stick_state);
               errors++;
            end else begin
               want = state_changes_due.pop_front();
               state_seen[want.state]++;
               if (rsp_chan_out !== want.chan) begin
                  $error("chan_out mismatch: expected %0d, got %0d", want.chan, rsp_chan_out);
                  errors++;
               end
               if (rsp_stick_state !== want.state) begin
                  $error("stick_state mismatch: expected %0d, got %0d", want.state,
                         rsp_stick_state);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            cmd_seen[req_cmd]++;
            seen.cmd = req_cmd;
            seen.chan = req_channel;
            seen.stamp = req_timestamp;
            chg = predict_stick_change(seen);
            if (chg.hit) state_changes_due.push_back(chg);
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (++quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("FAIL pwm_pulse_position_classifier");
         $finish;
      end
   end

   initial begin
      int        pick;
      int        n;
      int        band;
      int        start;
      logic      ch;
      stamp_type per;
      stamp_type wid;

      // Predictor reset state mirrors the block's reset.
      cfg_win[ppc_pkg::REG_POS1_WINDOW] = ppc_pkg::RST_POS1_WINDOW;
      cfg_win[ppc_pkg::REG_POS2_WINDOW] = ppc_pkg::RST_POS2_WINDOW;
      cfg_win[ppc_pkg::REG_POS3_WINDOW] = ppc_pkg::RST_POS3_WINDOW;
      cfg_win[ppc_pkg::REG_LOST_WINDOW] = ppc_pkg::RST_LOST_WINDOW;
      cfg_win[ppc_pkg::REG_PERIOD_WINDOW] = ppc_pkg::RST_PERIOD_WINDOW;
      cfg_ctrl = ppc_pkg::RST_CONTROL;
      cfg_timeout = ppc_pkg::RST_LOST_TIMEOUT;
      for (int c = 0; c < ppc_pkg::EDGE_CHANNELS; c++) begin
         rise_at[c] = '0;
         period_of[c] = '0;
         width_of[c] = '0;
         period_bad[c] = '0;
         width_bad[c] = '0;
         stick[c] = ppc_pkg::ST_NO_STICK;
         lost_timer[c] = '0;
         lost_armed[c] = (c == 0);
         gen_rise[c] = '0;
         for (int b = 0; b < ppc_pkg::NUM_BANDS; b++) band_runs[c][b] = '0;
      end
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (state_seen[i]) state_seen[i] = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset settings: ignored command, equal stamps on a channel
      // whose scan is off, a run into position 1, then wrapped period and width.
      push_req(CMD_UNUSED, 1'b1, 16'hffff);
      push_req(ppc_pkg::CMD_RISE, 1'b1, 16'hffff);
      push_req(ppc_pkg::CMD_FALL, 1'b1, 16'hffff);
      push_req(ppc_pkg::CMD_RISE, 1'b0, 16'h0000);
      push_req(ppc_pkg::CMD_FALL, 1'b0, 16'd100);
      for (int k = 1; k < 4; k++) begin
         push_req(ppc_pkg::CMD_RISE, 1'b0, stamp_type'(k * 2000));
         push_req(ppc_pkg::CMD_FALL, 1'b0, stamp_type'(k * 2000 + 100));
      end
      push_req(ppc_pkg::CMD_TICK, 1'b1, 16'h5a5a);
      push_req(ppc_pkg::CMD_RISE, 1'b0, 16'd65000);
      push_req(ppc_pkg::CMD_FALL, 1'b0, 16'd500);
      push_req(ppc_pkg::CMD_RISE, 1'b0, 16'd1464);
      push_req(ppc_pkg::CMD_FALL, 1'b0, 16'd1664);
      settle();

      // Both scans on, detect count zero and a timeout of one tick, so that
      // one tick expires both timers; a write past the register list is dropped.
      write_reg(REG_UNUSED, 32'hdead_beef);
      write_reg(ppc_pkg::REG_CONTROL, {6'd0, 2'b11, 8'd3, 8'd3, 8'd0});
      write_reg(ppc_pkg::REG_LOST_TIMEOUT, 32'd1);
      settings++;
      push_req(ppc_pkg::CMD_FALL, 1'b1, 16'h0097);
      push_req(ppc_pkg::CMD_TICK, 1'b0, 16'h0000);
      push_req(ppc_pkg::CMD_TICK, 1'b1, 16'hffff);
      push_req(ppc_pkg::CMD_FALL, 1'b0, 16'h0000);
      settle();

      // Random phases, each under its own register setting and idling mode.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: program_regs(ppc_pkg::RST_POS1_WINDOW, ppc_pkg::RST_POS2_WINDOW,
                            ppc_pkg::RST_POS3_WINDOW, ppc_pkg::RST_LOST_WINDOW,
                            ppc_pkg::RST_PERIOD_WINDOW,
                            ppc_pkg::RST_CONTROL | 26'(1 << (ppc_pkg::CTRL_SCAN_LSB + 1)),
                            32'd499);
            1: program_regs(ppc_pkg::RST_POS1_WINDOW, ppc_pkg::RST_POS2_WINDOW,
                            ppc_pkg::RST_POS3_WINDOW, ppc_pkg::RST_LOST_WINDOW,
                            ppc_pkg::RST_PERIOD_WINDOW, {6'd0, 2'b11, 8'd1, 8'd1, 8'd0},
                            32'd20);
            2: program_regs('1, '1, '1, '1, '1, '1, 32'd1);
            3: program_regs('0, '0, '0, '0, '0, '0, 32'd499);
            default: program_regs(rand_window(20, 400, 80), rand_window(20, 400, 80),
                                  rand_window(20, 400, 80), rand_window(0, 10, 30),
                                  rand_window(100, 3000, 2000),
                                  {6'd0, 2'($urandom_range(1, 3)), 8'($urandom_range(0, 5)),
                                   8'($urandom_range(0, 5)), 8'($urandom_range(0, 6))},
                                  32'($urandom_range(1, 60)));
         endcase
         case ((p + 3) % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 48; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 48; end
            default: begin sender_idle_pct = 37; rsp_stall_pct = 37; end
         endcase

         // Mostly well-formed pulse trains held in one band or of random width,
         // mixed with tick bursts and stray requests.
         start = queued;
         while (queued - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        stamp_type'($urandom));
            end else if (pick < 16) begin
               n = $urandom_range(1, (cfg_timeout < 38) ? cfg_timeout + 2 : 40);
               repeat (n)
                  push_req(ppc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), stamp_type'($urandom));
            end else begin
               ch = 1'($urandom_range(0, 1));
               band = $urandom_range(0, ppc_pkg::NUM_BANDS);
               repeat ($urandom_range(1, 8)) begin
                  if ($urandom_range(0, 99) < 85)
                     per = pick_in(cfg_win[ppc_pkg::REG_PERIOD_WINDOW]);
                  else per = stamp_type'($urandom_range(0, 65535));
                  if (band < ppc_pkg::NUM_BANDS) wid = pick_in(cfg_win[band]);
                  else wid = stamp_type'($urandom_range(0, 65535));
                  gen_rise[ch] = gen_rise[ch] + per;
                  push_req(ppc_pkg::CMD_RISE, ch, gen_rise[ch]);
                  if ($urandom_range(0, 99) < 20)
                     push_req(ppc_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
                              stamp_type'($urandom));
                  push_req(ppc_pkg::CMD_FALL, ch, gen_rise[ch] + wid);
               end
            end
         end

         // Detect count zero makes changes frequent, so a long hold fills the block.
         if (p == 1) hold_request = 1'b1;
         settle();
      end

      if (state_changes_due.size() != 0) begin
         $error("%0d expected state changes never arrived", state_changes_due.size());
         errors++;
      end
      $display("Covered %0d requests (%0d rise, %0d fall, %0d tick, %0d ignored)",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
               cmd_seen[ppc_pkg::CMD_RISE], cmd_seen[ppc_pkg::CMD_FALL],
               cmd_seen[ppc_pkg::CMD_TICK], cmd_seen[CMD_UNUSED]);
      $display("under %0d settings and %0d register writes; checked %0d state changes:",
               settings, reg_writes, results_seen);
      $display("no stick %0d, lost %0d, pos1 %0d, pos2 %0d, pos3 %0d.",
               state_seen[ppc_pkg::ST_NO_STICK], state_seen[ppc_pkg::ST_LOST],
               state_seen[ppc_pkg::ST_POS1], state_seen[ppc_pkg::ST_POS2],
               state_seen[ppc_pkg::ST_POS3]);
      if (errors == 0) begin
         $display("PASS pwm_pulse_position_classifier");
      end else begin
         $display("FAIL pwm_pulse_position_classifier");
      end
      $finish;
   end

endmodule
